// ===== rtl/gbs_pkg.sv =====
package gbs_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);

  localparam logic [1:0] REG_SCORE_THR   = 2'd0;
  localparam logic [1:0] REG_OVERLAP_THR = 2'd1;
  localparam logic [1:0] REG_KEEP_LIMIT  = 2'd2;

  typedef struct packed {
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
  } box_t;

  typedef struct packed {
    logic signed [15:0] box_xmin;
    logic signed [15:0] box_ymin;
    logic signed [15:0] box_xmax;
    logic signed [15:0] box_ymax;
    logic [15:0]        box_score;
    logic               final_box;
  } gbs_in_t;

  typedef struct packed {
    logic [5:0]  kept_index;
    logic [15:0] kept_score;
    logic        entry_valid;
    logic        final_result;
  } gbs_out_t;

  typedef struct packed {
    logic             valid;
    logic [15:0]      score;
    logic [IDX_W-1:0] idx;
  } cell_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic pop;
  } cell_ctl_t;

  typedef struct packed {
    box_t             box;
    logic [31:0]      area;
    logic [IDX_W-1:0] idx;
    logic [15:0]      score;
  } kept_t;

  // length of one side, zero when the edges are reversed
  function automatic logic [15:0] side_len(logic signed [15:0] lo, logic signed [15:0] hi);
    logic signed [16:0] d;
    d = $signed({hi[15], hi}) - $signed({lo[15], lo});
    return (d > 17'sd0) ? d[15:0] : 16'd0;
  endfunction

endpackage

// ===== rtl/greedy_box_suppression_core.sv =====
// Greedy non-maximum suppression over one set of up to MAX_BOXES boxes. Boxes load one
// beat per cycle while the core is loading; boxes above the score threshold are placed in
// score order on arrival by a row of insertion cells, so no sort pass follows. After the
// beat marked final_box the candidates leave the row one by one and each is checked against
// the boxes kept so far by a pipelined IoU unit, until one overlaps it beyond the threshold.
// Results then leave one beat at a time, each held until it is taken; no new box is taken
// until the last result is taken.
module greedy_box_suppression_core
  import gbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  gbs_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output gbs_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [9:0] {
    S_LOAD     = 10'b0000000001,
    S_CAND_RD  = 10'b0000000010,
    S_CAND_LEN = 10'b0000000100,
    S_CAND_MUL = 10'b0000001000,
    S_CMP_RD   = 10'b0000010000,
    S_CMP_GO   = 10'b0000100000,
    S_CMP_WAIT = 10'b0001000000,
    S_EMIT_RD  = 10'b0010000000,
    S_EMIT_LD  = 10'b0100000000,
    S_EMIT_OUT = 10'b1000000000
  } state_t;

  state_t state;

  logic [15:0]      score_thr, overlap_thr;
  logic [7:0]       keep_limit;
  logic [CNT_W-1:0] loaded_cnt, ins_cnt, cand_left, kept_cnt, j, e;

  box_t             box_mem [MAX_BOXES];
  box_t             box_rd;
  kept_t            kept_mem [MAX_BOXES];
  kept_t            k_rd;
  logic [IDX_W-1:0] k_addr;

  cell_t            cell_q [MAX_BOXES];
  cell_ctl_t        ctl;
  cell_t            new_entry;

  box_t             cand_box;
  logic [15:0]      wa, ha, cand_score;
  logic [31:0]      cand_area;
  logic [IDX_W-1:0] cand_idx;

  logic             accept, room, do_insert;
  logic [CNT_W-1:0] ins_cnt_next;
  logic [15:0]      lim_ext;
  logic             iou_start, iou_done, iou_ok;
  gbs_out_t         out_reg;

  assign in_ready  = (state == S_LOAD);
  assign accept    = in_valid && in_ready;
  assign room      = (loaded_cnt < CNT_W'(MAX_BOXES));
  assign do_insert = accept && room && (in_data.box_score > score_thr);
  assign ins_cnt_next = ins_cnt + CNT_W'(do_insert);
  assign lim_ext   = 16'(keep_limit);
  assign iou_start = (state == S_CMP_GO);
  assign out_data  = out_reg;

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.score = in_data.box_score;
    new_entry.idx   = loaded_cnt[IDX_W-1:0];
    ctl.insert      = do_insert;
    ctl.pop         = (state == S_CAND_RD) && (cand_left != '0);
    ctl.clear       = (state == S_CAND_RD) && (cand_left == '0);
    k_addr          = (state == S_EMIT_RD) ? e[IDX_W-1:0] : j[IDX_W-1:0];
  end

  // insertion row: the head cell always holds the best remaining candidate
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    cell_t prev_in, next_in;
    if (i == 0) begin : g_head
      assign prev_in = '{valid: 1'b1, score: '1, idx: '0};
    end else begin : g_mid
      assign prev_in = cell_q[i-1];
    end
    if (i == MAX_BOXES - 1) begin : g_tail
      assign next_in = '0;
    end else begin : g_body
      assign next_in = cell_q[i+1];
    end
    gbs_sort_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .new_entry(new_entry),
      .prev_q(prev_in), .next_q(next_in), .q(cell_q[i])
    );
  end

  gbs_iou u_iou (
    .clk(clk), .rst(rst), .start(iou_start),
    .a(cand_box), .area_a(cand_area), .b(k_rd.box), .area_b(k_rd.area),
    .thr(overlap_thr), .done(iou_done), .ok(iou_ok)
  );

  always_ff @(posedge clk) begin
    if (accept && room) begin
      box_mem[loaded_cnt[IDX_W-1:0]] <= '{x0: in_data.box_xmin, y0: in_data.box_ymin,
                                          x1: in_data.box_xmax, y1: in_data.box_ymax};
    end
    box_rd <= box_mem[cell_q[0].idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_CMP_RD && j == kept_cnt) begin
      kept_mem[kept_cnt[IDX_W-1:0]] <= '{box: cand_box, area: cand_area,
                                         idx: cand_idx, score: cand_score};
    end
    k_rd <= kept_mem[k_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_thr   <= 16'd39322;
      overlap_thr <= 16'd19661;
      keep_limit  <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCORE_THR:   score_thr   <= cfg_data;
        REG_OVERLAP_THR: overlap_thr <= cfg_data;
        REG_KEEP_LIMIT:  keep_limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      loaded_cnt <= '0;
      ins_cnt    <= '0;
      kept_cnt   <= '0;
      cand_left  <= '0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (in_data.final_box) begin
              loaded_cnt <= '0;
              ins_cnt    <= '0;
              kept_cnt   <= '0;
              // negative limit means no cut
              if (!keep_limit[7] && lim_ext < 16'(ins_cnt_next))
                cand_left <= CNT_W'(lim_ext);
              else
                cand_left <= ins_cnt_next;
              state <= S_CAND_RD;
            end else begin
              loaded_cnt <= room ? loaded_cnt + CNT_W'(1) : loaded_cnt;
              ins_cnt    <= ins_cnt_next;
            end
          end
        end
        S_CAND_RD: begin
          if (cand_left == '0) begin
            e     <= '0;
            state <= S_EMIT_RD;
          end else begin
            cand_idx   <= cell_q[0].idx;
            cand_score <= cell_q[0].score;
            cand_left  <= cand_left - CNT_W'(1);
            state      <= S_CAND_LEN;
          end
        end
        S_CAND_LEN: begin
          cand_box <= box_rd;
          wa       <= side_len(box_rd.x0, box_rd.x1);
          ha       <= side_len(box_rd.y0, box_rd.y1);
          state    <= S_CAND_MUL;
        end
        S_CAND_MUL: begin
          cand_area <= wa * ha;
          j         <= '0;
          state     <= S_CMP_RD;
        end
        S_CMP_RD: begin
          if (j == kept_cnt) begin
            kept_cnt <= kept_cnt + CNT_W'(1);
            state    <= S_CAND_RD;
          end else begin
            state <= S_CMP_GO;
          end
        end
        S_CMP_GO: state <= S_CMP_WAIT;
        S_CMP_WAIT: begin
          if (iou_done) begin
            if (iou_ok) begin
              j     <= j + CNT_W'(1);
              state <= S_CMP_RD;
            end else begin
              state <= S_CAND_RD;
            end
          end
        end
        S_EMIT_RD: begin
          if (kept_cnt == '0) begin
            out_reg   <= '{kept_index: '0, kept_score: '0, entry_valid: 1'b0,
                           final_result: 1'b1};
            out_valid <= 1'b1;
            state     <= S_EMIT_OUT;
          end else begin
            state <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          out_reg   <= '{kept_index: 6'(k_rd.idx), kept_score: k_rd.score, entry_valid: 1'b1,
                         final_result: (e + CNT_W'(1) == kept_cnt)};
          out_valid <= 1'b1;
          state     <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_reg.final_result) begin
              state <= S_LOAD;
            end else begin
              e     <= e + CNT_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_out_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_EMIT_OUT)
    else $error("result beat outside emit");

  a_cmp_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP_WAIT |-> j < kept_cnt)
    else $error("compare index past kept list");

  a_last_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_reg.final_result) |=> state == S_LOAD && loaded_cnt == '0)
    else $error("set did not end after last beat");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept_cnt <= CNT_W'(MAX_BOXES))
    else $error("kept count overflow");

endmodule

// ===== rtl/gbs_sort_cell.sv =====
module gbs_sort_cell
  import gbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  cell_t     new_entry,
  input  cell_t     prev_q,
  input  cell_t     next_q,
  output cell_t     q
);

  cell_t q_next;
  logic  prev_ge;
  logic  self_ge;

  always_comb begin
    prev_ge = prev_q.valid && (prev_q.score >= new_entry.score);
    self_ge = q.valid && (q.score >= new_entry.score);
    q_next  = q;
    priority if (ctl.clear) begin
      q_next.valid = 1'b0;
    end else if (ctl.pop) begin
      q_next = next_q;
    end else if (ctl.insert) begin
      // equal scores stay ahead of the newcomer
      priority if (self_ge) q_next = q;
      else if (prev_ge)     q_next = new_entry;
      else                  q_next = prev_q;
    end else begin
      q_next = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) q.valid <= 1'b0;
    else     q <= q_next;
  end

endmodule

// ===== rtl/gbs_iou.sv =====
module gbs_iou
  import gbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  box_t        a,
  input  logic [31:0] area_a,
  input  box_t        b,
  input  logic [31:0] area_b,
  input  logic [15:0] thr,
  output logic        done,
  output logic        ok
);

  logic [3:0]  stage_v;
  logic [15:0] iw, ih;
  logic        zero_area;
  logic [32:0] area_sum, area_sum2;
  logic [31:0] inter, inter2;
  logic [32:0] uni;
  logic [48:0] lhs, rhs;

  always_ff @(posedge clk) begin
    if (rst) stage_v <= '0;
    else     stage_v <= {stage_v[2:0], start};
  end

  always_ff @(posedge clk) begin
    iw        <= side_len((a.x0 > b.x0) ? a.x0 : b.x0, (a.x1 < b.x1) ? a.x1 : b.x1);
    ih        <= side_len((a.y0 > b.y0) ? a.y0 : b.y0, (a.y1 < b.y1) ? a.y1 : b.y1);
    zero_area <= (area_a == 32'd0) || (area_b == 32'd0);
    area_sum  <= {1'b0, area_a} + {1'b0, area_b};
    inter     <= zero_area ? 32'd0 : iw * ih;
    area_sum2 <= area_sum;
    uni       <= area_sum2 - {1'b0, inter};
    inter2    <= inter;
  end

  always_comb begin
    lhs  = {1'b0, inter2, 16'd0};
    rhs  = 49'(thr) * 49'(uni);
    ok   = (uni == 33'd0) || (lhs <= rhs);
    done = stage_v[3];
  end

endmodule
